// ===== rtl/tcpu_pkg.sv =====
// Package of shared types, codes and constants for the toy CPU execute unit.
`default_nettype none
package tcpu_pkg;
  localparam int NUM_REGS_DEF    = 16;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int IP_IDX          = 10;
  localparam int FL_IDX          = 11;
  localparam logic [15:0] SKIP_BYTES = 16'd4;
  localparam logic [1:0]  FIELD_SET  = 2'b01;
  localparam logic [1:0]  FIELD_MASK = 2'b11;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_KIND = 3'd1, ST_HALT = 3'd2,
    ST_OVER = 3'd3, ST_UNDER = 3'd4, ST_REG = 3'd5
  } status_t;

  localparam logic [4:0] OP_HLT = 5'd0,  OP_MOV = 5'd1,  OP_ADD = 5'd2,  OP_SUB = 5'd3;
  localparam logic [4:0] OP_XOR = 5'd4,  OP_OR  = 5'd5,  OP_MUL = 5'd6,  OP_INC = 5'd7;
  localparam logic [4:0] OP_DEC = 5'd8,  OP_CMP = 5'd9,  OP_JMP = 5'd10, OP_JIE = 5'd11;
  localparam logic [4:0] OP_JIG = 5'd12, OP_JIL = 5'd13, OP_JEG = 5'd14, OP_JEL = 5'd15;
  localparam logic [4:0] OP_JNE = 5'd16, OP_CALL = 5'd17, OP_RET = 5'd18;
  localparam logic [4:0] OP_PUSH = 5'd19, OP_POP = 5'd20;

  localparam logic [1:0] KIND_REG = 2'd0, KIND_IMM = 2'd1;

  // Classified instruction handed from the front to the back.
  typedef struct packed {
    logic [4:0]  op;
    status_t     status;   // ST_OK or an early error
    logic        use1_reg;
    logic        use2_reg;
    logic [15:0] a1;
    logic [15:0] a2;
  } uop_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] ip_after;
    logic [15:0] flags_after;
    logic        reg_written;
    logic [3:0]  written_index;
    logic [15:0] written_value;
  } res_t;
endpackage
`default_nettype wire

// ===== rtl/tcpu_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none
module tcpu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/tcpu_front.sv =====
// Front end: checks operand kinds and register indices, classifies the item.
`default_nettype none
module tcpu_front #(
  parameter int NUM_REGS = tcpu_pkg::NUM_REGS_DEF
) (
  input  wire logic [4:0]  op,
  input  wire logic [1:0]  k1,
  input  wire logic [1:0]  k2,
  input  wire logic [15:0] a1,
  input  wire logic [15:0] a2,
  output tcpu_pkg::uop_t   uop
);
  // 0 none, 1 register only, 2 register or immediate
  logic [1:0] need1, need2;
  logic kbad, ibad, kbad1, kbad2, ibad1, ibad2, unk, halt;

  always_comb begin
    need1 = 2'd0; need2 = 2'd0; unk = 1'b0; halt = 1'b0;
    case (op) inside
      tcpu_pkg::OP_HLT: halt = 1'b1;
      [tcpu_pkg::OP_MOV:tcpu_pkg::OP_MUL]: begin need1 = 2'd1; need2 = 2'd2; end
      tcpu_pkg::OP_INC, tcpu_pkg::OP_DEC, tcpu_pkg::OP_POP: need1 = 2'd1;
      tcpu_pkg::OP_CMP: begin need1 = 2'd2; need2 = 2'd2; end
      [tcpu_pkg::OP_JMP:tcpu_pkg::OP_CALL], tcpu_pkg::OP_PUSH: need1 = 2'd2;
      tcpu_pkg::OP_RET: need1 = 2'd0;
      default: unk = 1'b1;
    endcase
    kbad1 = (need1 != 2'd0) && ((k1 > 2'd1) || (need1 == 2'd1 && k1 == tcpu_pkg::KIND_IMM));
    kbad2 = (need2 != 2'd0) && ((k2 > 2'd1) || (need2 == 2'd1 && k2 == tcpu_pkg::KIND_IMM));
    ibad1 = (need1 != 2'd0) && k1 == tcpu_pkg::KIND_REG && a1 >= 16'(NUM_REGS);
    ibad2 = (need2 != 2'd0) && k2 == tcpu_pkg::KIND_REG && a2 >= 16'(NUM_REGS);
    kbad = kbad1 || kbad2;
    ibad = ibad1 || ibad2;
    uop.op = op;
    uop.a1 = a1;
    uop.a2 = a2;
    uop.use1_reg = (k1 == tcpu_pkg::KIND_REG);
    uop.use2_reg = (k2 == tcpu_pkg::KIND_REG);
    if (halt)             uop.status = tcpu_pkg::ST_HALT;
    else if (unk || kbad) uop.status = tcpu_pkg::ST_KIND;
    else if (ibad)        uop.status = tcpu_pkg::ST_REG;
    else                  uop.status = tcpu_pkg::ST_OK;
  end
endmodule
`default_nettype wire

// ===== rtl/tcpu_queue.sv =====
// Short two-entry queue between the front and the back.
`default_nettype none
module tcpu_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output      logic             full,
  input  wire logic             rd,
  output      logic [WIDTH-1:0] rdata,
  output      logic             empty
);
  logic [WIDTH-1:0] slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = slot_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) slot_r[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

// ===== rtl/tcpu_back.sv =====
// Back end: registers, stack, result queue; one item per cycle unless stalled.
`default_nettype none
module tcpu_back #(
  parameter int NUM_REGS    = tcpu_pkg::NUM_REGS_DEF,
  parameter int STACK_DEPTH = tcpu_pkg::STACK_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           uq_empty,
  input  wire tcpu_pkg::uop_t uop,
  output      logic           uq_pop,
  output tcpu_pkg::res_t      res,
  output      logic           res_empty,
  input  wire logic           res_pop
);
  localparam int RW = $clog2(NUM_REGS);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  logic [15:0] regs_r [NUM_REGS];
  logic [PW-1:0] sp_r, sp_nxt;

  // Stage 2 holds a pop or ret awaiting the stack read data.
  logic        s2_v_r, s2_ret_r;
  logic [RW-1:0] s2_idx_r;
  logic [3:0]  s2_idx4_r;
  logic [15:0] sdata;

  // Output path: the stage 1 result r1 (combinational) and the queue after it.
  logic oq_full;
  logic go;
  tcpu_pkg::res_t r1;
  logic r1_v, push2;

  logic [15:0] ip, fl, v1, v2, wv;
  logic        wr, take, st_we;
  logic [15:0] st_wd;
  tcpu_pkg::status_t st;
  logic [15:0] ip_n, fl_n;
  logic [RW-1:0] i1;

  // Stage 2 holds one slot; stall new work while a result cannot be queued.
  assign go = !uq_empty && !oq_full;
  assign uq_pop = go;
  assign i1 = uop.a1[RW-1:0];

  // Register view with bypass from stage 2 (pop/ret write in stage 2).
  function automatic logic [15:0] rd_reg(input logic [RW-1:0] i,
      input logic [15:0] r, input logic b, input logic [RW-1:0] bi,
      input logic [15:0] bv);
    return (b && bi == i) ? bv : r;
  endfunction

  logic b_v;
  logic [RW-1:0] b_i;
  assign b_v = s2_v_r;
  assign b_i = s2_ret_r ? RW'(tcpu_pkg::IP_IDX) : s2_idx_r;

  always_comb begin
    ip = rd_reg(RW'(tcpu_pkg::IP_IDX), regs_r[tcpu_pkg::IP_IDX], b_v, b_i, sdata);
    fl = rd_reg(RW'(tcpu_pkg::FL_IDX), regs_r[tcpu_pkg::FL_IDX], b_v, b_i, sdata);
    v1 = uop.use1_reg ? rd_reg(i1, regs_r[i1], b_v, b_i, sdata) : uop.a1;
    v2 = uop.use2_reg ? rd_reg(uop.a2[RW-1:0], regs_r[uop.a2[RW-1:0]], b_v, b_i, sdata)
                      : uop.a2;
    st = uop.status; wr = 1'b0; wv = 16'd0; ip_n = ip; fl_n = fl;
    st_we = 1'b0; st_wd = 16'd0; sp_nxt = sp_r; take = 1'b0;
    if (st == tcpu_pkg::ST_OK) begin
      case (uop.op)
        tcpu_pkg::OP_MOV: begin wv = v2; wr = 1'b1; end
        tcpu_pkg::OP_ADD: begin wv = v1 + v2; wr = 1'b1; end
        tcpu_pkg::OP_SUB: begin wv = v1 - v2; wr = 1'b1; end
        tcpu_pkg::OP_XOR: begin wv = v1 ^ v2; wr = 1'b1; end
        tcpu_pkg::OP_OR:  begin wv = v1 | v2; wr = 1'b1; end
        tcpu_pkg::OP_MUL: begin wv = 16'(32'(v1) * 32'(v2)); wr = 1'b1; end
        tcpu_pkg::OP_INC: begin wv = v1 + 16'd1; wr = 1'b1; end
        tcpu_pkg::OP_DEC: begin wv = v1 - 16'd1; wr = 1'b1; end
        tcpu_pkg::OP_CMP: begin
          if (v1 == v2)     fl_n = {tcpu_pkg::FIELD_SET, 14'd0};
          else if (v1 > v2) fl_n = {2'b00, tcpu_pkg::FIELD_SET, 12'd0};
          else              fl_n = {4'b0000, tcpu_pkg::FIELD_SET, 10'd0};
        end
        tcpu_pkg::OP_JMP: ip_n = v1;
        tcpu_pkg::OP_JIE, tcpu_pkg::OP_JIG, tcpu_pkg::OP_JIL,
        tcpu_pkg::OP_JEG, tcpu_pkg::OP_JEL, tcpu_pkg::OP_JNE: begin
          case (uop.op)
            tcpu_pkg::OP_JIE: take = (fl[15:14] & tcpu_pkg::FIELD_MASK) == tcpu_pkg::FIELD_SET;
            tcpu_pkg::OP_JIG: take = fl[13:12] == tcpu_pkg::FIELD_SET;
            tcpu_pkg::OP_JIL: take = fl[11:10] == tcpu_pkg::FIELD_SET;
            tcpu_pkg::OP_JEG: take = fl[15:14] == tcpu_pkg::FIELD_SET ||
                                     fl[13:12] == tcpu_pkg::FIELD_SET;
            tcpu_pkg::OP_JEL: take = fl[15:14] == tcpu_pkg::FIELD_SET ||
                                     fl[11:10] == tcpu_pkg::FIELD_SET;
            default:          take = fl[15:14] == 2'b00;
          endcase
          ip_n = take ? v1 : ip + tcpu_pkg::SKIP_BYTES;
        end
        tcpu_pkg::OP_CALL, tcpu_pkg::OP_PUSH: begin
          if (sp_r == PW'(STACK_DEPTH)) st = tcpu_pkg::ST_OVER;
          else begin
            st_we = 1'b1; sp_nxt = sp_r + 1'b1;
            if (uop.op == tcpu_pkg::OP_CALL) begin
              st_wd = ip + tcpu_pkg::SKIP_BYTES; ip_n = v1;
            end else st_wd = v1;
          end
        end
        tcpu_pkg::OP_RET, tcpu_pkg::OP_POP: begin
          if (sp_r == '0) st = tcpu_pkg::ST_UNDER;
          else sp_nxt = sp_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic is_sr;
  assign is_sr = go && st == tcpu_pkg::ST_OK &&
                 (uop.op == tcpu_pkg::OP_RET || uop.op == tcpu_pkg::OP_POP);

  tcpu_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(go && st_we), .waddr(sp_r[SW-1:0]), .wdata(st_wd),
    .raddr(sp_nxt[SW-1:0]), .rdata(sdata)
  );

  // Results: stage 1 results go straight in; stage 2 results resolve next cycle.
  // Order is kept because a stage 2 item writes its result register slot and
  // the stage 1 item of the same cycle follows it.
  tcpu_pkg::res_t s2_res;
  always_comb begin
    s2_res.status = tcpu_pkg::ST_OK;
    s2_res.ip_after = ip;
    s2_res.flags_after = fl;
    s2_res.reg_written = !s2_ret_r;
    s2_res.written_index = s2_ret_r ? 4'd0 : s2_idx4_r;
    s2_res.written_value = s2_ret_r ? 16'd0 : sdata;
    r1.status = st;
    r1.ip_after = (st == tcpu_pkg::ST_OK) ? ip_n : ip;
    r1.flags_after = (st == tcpu_pkg::ST_OK) ? fl_n : fl;
    r1.reg_written = wr;
    r1.written_index = wr ? uop.a1[3:0] : 4'd0;
    r1.written_value = wr ? wv : 16'd0;
    // A stage 1 write to IP or FL must show in the values reported.
    if (wr && i1 == RW'(tcpu_pkg::IP_IDX)) r1.ip_after = wv;
    if (wr && i1 == RW'(tcpu_pkg::FL_IDX)) r1.flags_after = wv;
  end

  // Two results can enter in a cycle; a small queue with two write ports.
  // New work is taken while at most two entries wait, which leaves room for
  // a stage 1 result and a stage 2 result arriving in the next cycles.
  tcpu_pkg::res_t q_r [4];
  logic [1:0] qw_r, qr_r;
  logic [2:0] qc_r, qc_nxt;
  assign r1_v = go && !is_sr;
  assign push2 = s2_v_r;
  assign oq_full = qc_r > 3'd2;
  assign res_empty = (qc_r == 3'd0);
  assign res = q_r[qr_r];
  always_comb qc_nxt = qc_r + {2'b0, r1_v} + {2'b0, push2} - {2'b0, res_pop && !res_empty};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0; s2_v_r <= 1'b0; qw_r <= '0; qr_r <= '0; qc_r <= '0;
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= 16'd0;
    end else begin
      sp_r <= sp_nxt & {PW{go}} | sp_r & {PW{!go}};
      if (s2_v_r) regs_r[b_i] <= sdata;
      if (go && st == tcpu_pkg::ST_OK) begin
        regs_r[tcpu_pkg::IP_IDX] <= ip_n;
        regs_r[tcpu_pkg::FL_IDX] <= fl_n;
        if (wr) regs_r[i1] <= wv;
      end
      s2_v_r <= is_sr;
      if (push2 && r1_v) begin
        q_r[qw_r] <= s2_res; q_r[qw_r + 2'd1] <= r1; qw_r <= qw_r + 2'd2;
      end else if (push2) begin
        q_r[qw_r] <= s2_res; qw_r <= qw_r + 2'd1;
      end else if (r1_v) begin
        q_r[qw_r] <= r1; qw_r <= qw_r + 2'd1;
      end
      if (res_pop && !res_empty) qr_r <= qr_r + 2'd1;
      qc_r <= qc_nxt;
    end
    s2_ret_r <= uop.op == tcpu_pkg::OP_RET;
    s2_idx_r <= i1;
    s2_idx4_r <= uop.a1[3:0];
  end
endmodule
`default_nettype wire

// ===== rtl/toy_cpu_execute_unit.sv =====
// Top level of the toy CPU execute unit: front classifier, queue, back end.
// Items pass the input queue to the back end; pop and ret wait in stage two for
// the stack memory read. New items stall while three results or more wait.
// Throughput: one item per cycle when not stalled; register file and stack port
// each serve one item a cycle, and the result queue absorbs a stage-two result.
// Reset (rst_n low, synchronous) empties both queues, zeroes all registers and
// the stack pointer; stack contents are not cleared.
`default_nettype none
module toy_cpu_execute_unit #(
  parameter int NUM_REGS    = tcpu_pkg::NUM_REGS_DEF,
  parameter int STACK_DEPTH = tcpu_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [4:0]  in_op,
  input  wire logic [1:0]  in_first_kind,
  input  wire logic [1:0]  in_second_kind,
  input  wire logic [15:0] in_first_arg,
  input  wire logic [15:0] in_second_arg,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [2:0]  out_status,
  output      logic [15:0] out_ip_after,
  output      logic [15:0] out_flags_after,
  output      logic        out_reg_written,
  output      logic [3:0]  out_written_index,
  output      logic [15:0] out_written_value
);
  tcpu_pkg::uop_t fuop, buop;
  tcpu_pkg::res_t res;
  logic uq_empty, uq_pop;

  // The front decodes in the cycle of the push; the queue holds classified items.
  tcpu_front #(.NUM_REGS(NUM_REGS)) u_front (
    .op(in_op), .k1(in_first_kind), .k2(in_second_kind),
    .a1(in_first_arg), .a2(in_second_arg), .uop(fuop)
  );

  tcpu_queue #(.WIDTH($bits(tcpu_pkg::uop_t))) u_queue (
    .clk(clk), .rst_n(rst_n), .wr(push && !full), .wdata(fuop), .full(full),
    .rd(uq_pop), .rdata(buop), .empty(uq_empty)
  );

  // The back executes in order and keeps its own result queue.
  tcpu_back #(.NUM_REGS(NUM_REGS), .STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .uq_empty(uq_empty), .uop(buop), .uq_pop(uq_pop),
    .res(res), .res_empty(empty), .res_pop(pop)
  );

  assign out_status        = res.status;
  assign out_ip_after      = res.ip_after;
  assign out_flags_after   = res.flags_after;
  assign out_reg_written   = res.reg_written;
  assign out_written_index = res.written_index;
  assign out_written_value = res.written_value;
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the toy CPU execute unit with a scoreboard class.
module tb_top;
  import tcpu_pkg::*;

  localparam int NREGS      = 16;
  localparam int SDEPTH     = 256;
  localparam int RAND_ITEMS = 1000;
  localparam int WATCH_MAX  = 5000;

  // The scoreboard keeps its own copy of the architectural state and a queue
  // of the results that the block still owes.
  class exec_scoreboard;
    logic [15:0] regs [NREGS];
    logic [15:0] stk [SDEPTH];
    int          depth;
    res_t        owed [$];
    int          errors;

    function void clear();
      foreach (regs[i]) regs[i] = 16'h0;
      depth  = 0;
      errors = 0;
      owed.delete();
    endfunction

    function logic [15:0] fetch(logic [1:0] kind, logic [15:0] arg);
      if (kind == KIND_REG) return (arg < NREGS) ? regs[arg] : 16'h0;
      return arg;
    endfunction

    function bit kind_ok(int need, logic [1:0] kind);
      if (need == 0) return 1;
      if (kind > KIND_IMM) return 0;
      return !(need == 1 && kind == KIND_IMM);
    endfunction

    function bit index_bad(int need, logic [1:0] kind, logic [15:0] arg);
      return need != 0 && kind == KIND_REG && arg >= NREGS;
    endfunction

    // Work out the result of one accepted instruction and queue it.
    function void note_instr(logic [4:0] op, logic [1:0] k1, logic [1:0] k2,
                             logic [15:0] a1, logic [15:0] a2);
      status_t     st;
      int          n1, n2;
      bit          wr, take;
      logic [15:0] v1, v2, fl, val;
      logic [31:0] prod;
      res_t        r;
      st = ST_OK; n1 = 0; n2 = 0; wr = 0; val = 16'h0;
      if (op == OP_HLT) st = ST_HALT;
      else if (op <= OP_MUL) begin n1 = 1; n2 = 2; end
      else if (op <= OP_DEC) n1 = 1;
      else if (op == OP_CMP) begin n1 = 2; n2 = 2; end
      else if (op <= OP_CALL) n1 = 2;
      else if (op == OP_RET) n1 = 0;
      else if (op == OP_PUSH) n1 = 2;
      else if (op == OP_POP) n1 = 1;
      else st = ST_KIND;
      if (st == ST_OK && !(kind_ok(n1, k1) && kind_ok(n2, k2))) st = ST_KIND;
      if (st == ST_OK && (index_bad(n1, k1, a1) || index_bad(n2, k2, a2))) st = ST_REG;
      if (st == ST_OK) begin
        v1 = fetch(k1, a1);
        v2 = fetch(k2, a2);
        fl = regs[FL_IDX];
        case (op)
          OP_MOV: begin val = v2; wr = 1; end
          OP_ADD: begin val = v1 + v2; wr = 1; end
          OP_SUB: begin val = v1 - v2; wr = 1; end
          OP_XOR: begin val = v1 ^ v2; wr = 1; end
          OP_OR:  begin val = v1 | v2; wr = 1; end
          OP_MUL: begin prod = v1 * v2; val = prod[15:0]; wr = 1; end
          OP_INC: begin val = v1 + 16'd1; wr = 1; end
          OP_DEC: begin val = v1 - 16'd1; wr = 1; end
          OP_CMP: begin
            if (v1 == v2) regs[FL_IDX] = 16'h4000;
            else if (v1 > v2) regs[FL_IDX] = 16'h1000;
            else regs[FL_IDX] = 16'h0400;
          end
          OP_JMP: regs[IP_IDX] = v1;
          OP_CALL: begin
            if (depth >= SDEPTH) st = ST_OVER;
            else begin
              stk[depth] = regs[IP_IDX] + SKIP_BYTES;
              depth++;
              regs[IP_IDX] = v1;
            end
          end
          OP_RET: begin
            if (depth == 0) st = ST_UNDER;
            else begin depth--; regs[IP_IDX] = stk[depth]; end
          end
          OP_PUSH: begin
            if (depth >= SDEPTH) st = ST_OVER;
            else begin stk[depth] = v1; depth++; end
          end
          OP_POP: begin
            if (depth == 0) st = ST_UNDER;
            else begin depth--; val = stk[depth]; wr = 1; end
          end
          default: begin
            // Conditional jumps test the 2-bit compare fields of the flags.
            case (op)
              OP_JIE: take = fl[15:14] == FIELD_SET;
              OP_JIG: take = fl[13:12] == FIELD_SET;
              OP_JIL: take = fl[11:10] == FIELD_SET;
              OP_JEG: take = fl[15:14] == FIELD_SET || fl[13:12] == FIELD_SET;
              OP_JEL: take = fl[15:14] == FIELD_SET || fl[11:10] == FIELD_SET;
              default: take = fl[15:14] == 2'b00;
            endcase
            regs[IP_IDX] = take ? v1 : regs[IP_IDX] + SKIP_BYTES;
          end
        endcase
        if (st == ST_OK && wr) regs[a1[3:0]] = val;
        else wr = 0;
      end
      r.status        = st;
      r.ip_after      = regs[IP_IDX];
      r.flags_after   = regs[FL_IDX];
      r.reg_written   = wr;
      r.written_index = wr ? a1[3:0] : 4'h0;
      r.written_value = wr ? val : 16'h0;
      owed.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.ip_after !== want.ip_after) begin
        $display("%0t: ip_after expected %h actual %h", $time, want.ip_after, got.ip_after);
        errors++;
      end
      if (got.flags_after !== want.flags_after) begin
        $display("%0t: flags_after expected %h actual %h", $time,
                 want.flags_after, got.flags_after);
        errors++;
      end
      if (got.reg_written !== want.reg_written) begin
        $display("%0t: reg_written expected %b actual %b", $time,
                 want.reg_written, got.reg_written);
        errors++;
      end
      if (got.written_index !== want.written_index) begin
        $display("%0t: written_index expected %0d actual %0d", $time,
                 want.written_index, got.written_index);
        errors++;
      end
      if (got.written_value !== want.written_value) begin
        $display("%0t: written_value expected %h actual %h", $time,
                 want.written_value, got.written_value);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [4:0]  in_op = '0;
  logic [1:0]  in_first_kind = '0;
  logic [1:0]  in_second_kind = '0;
  logic [15:0] in_first_arg = '0;
  logic [15:0] in_second_arg = '0;
  logic        full, empty;
  logic [2:0]  out_status;
  logic [15:0] out_ip_after, out_flags_after, out_written_value;
  logic        out_reg_written;
  logic [3:0]  out_written_index;

  exec_scoreboard sb = new();
  bit  quiet_tail;     // Set near the end: no idling on either side.
  bit  sending_done;
  int  hold_cycles;    // Long receiver hold-off, counted by the receiver.
  int  idle_watch;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  toy_cpu_execute_unit uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_op(in_op), .in_first_kind(in_first_kind), .in_second_kind(in_second_kind),
    .in_first_arg(in_first_arg), .in_second_arg(in_second_arg),
    .empty(empty), .pop(pop), .out_status(out_status), .out_ip_after(out_ip_after),
    .out_flags_after(out_flags_after), .out_reg_written(out_reg_written),
    .out_written_index(out_written_index), .out_written_value(out_written_value)
  );

  // Offer one instruction from the falling edge and hold it until the block
  // takes it. Push stays high into the next item unless a gap is drawn, so a
  // random idle burst is inserted before the offer when wanted.
  task automatic send_instr(logic [4:0] op, logic [1:0] k1, logic [1:0] k2,
                            logic [15:0] a1, logic [15:0] a2);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op <= op; in_first_kind <= k1; in_second_kind <= k2;
    in_first_arg <= a1; in_second_arg <= a2;
    push <= 1'b1;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    sb.note_instr(op, k1, k2, a1, a2);
    @(negedge clk);
  endtask

  // Random operand: any 16-bit value when wide, else mostly a valid register, sometimes out of range.
  function automatic logic [15:0] pick_arg(bit wide);
    if (wide || $urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, NREGS - 1));
  endfunction

  // Mostly legal kinds, with invalid ones mixed in.
  function automatic logic [1:0] pick_kind();
    if ($urandom_range(0, 11) == 0) return 2'($urandom_range(2, 3));
    return 2'($urandom_range(0, 1));
  endfunction

  task automatic send_random();
    logic [4:0] op;
    logic [1:0] k1, k2;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 2) op = 5'($urandom_range(21, 31));
    else if (sel < 4) op = OP_HLT;
    else if (sel < 20) op = 5'($urandom_range(OP_CALL, OP_POP));
    else op = 5'($urandom_range(OP_MOV, OP_JNE));
    k1 = pick_kind();
    k2 = pick_kind();
    send_instr(op, k1, k2, pick_arg(k1 == KIND_IMM), pick_arg(k2 == KIND_IMM));
  endtask

  task automatic run_directed();
    // Arithmetic at the value extremes, with wraparound.
    send_instr(OP_MOV, KIND_REG, KIND_IMM, 16'd0, 16'hFFFF);
    send_instr(OP_ADD, KIND_REG, KIND_IMM, 16'd0, 16'h0001);
    send_instr(OP_SUB, KIND_REG, KIND_IMM, 16'd1, 16'h0001);
    send_instr(OP_MOV, KIND_REG, KIND_IMM, 16'd15, 16'hA5A5);
    send_instr(OP_XOR, KIND_REG, KIND_REG, 16'd15, 16'd0);
    send_instr(OP_OR,  KIND_REG, KIND_IMM, 16'd2, 16'h8001);
    send_instr(OP_MUL, KIND_REG, KIND_REG, 16'd15, 16'd15);
    send_instr(OP_INC, KIND_REG, KIND_IMM, 16'd3, 16'd0);
    send_instr(OP_DEC, KIND_REG, KIND_IMM, 16'd4, 16'd0);
    // Compares setting each field, then taken and not-taken jumps.
    send_instr(OP_CMP, KIND_IMM, KIND_IMM, 16'd7, 16'd7);
    send_instr(OP_JIE, KIND_IMM, KIND_REG, 16'h1234, 16'd0);
    send_instr(OP_JNE, KIND_IMM, KIND_REG, 16'h4321, 16'd0);
    send_instr(OP_CMP, KIND_IMM, KIND_IMM, 16'hFFFF, 16'd0);
    send_instr(OP_JIG, KIND_IMM, KIND_REG, 16'hFFFE, 16'd0);
    send_instr(OP_CMP, KIND_REG, KIND_IMM, 16'd3, 16'hFFFF);
    send_instr(OP_JEL, KIND_REG, KIND_REG, 16'd0, 16'd0);
    send_instr(OP_JMP, KIND_IMM, KIND_REG, 16'hFFFE, 16'd0);
    // Stack: call/ret, push/pop and underflow on an empty stack.
    send_instr(OP_RET, KIND_REG, KIND_REG, 16'd0, 16'd0);
    send_instr(OP_POP, KIND_REG, KIND_REG, 16'd5, 16'd0);
    send_instr(OP_CALL, KIND_IMM, KIND_REG, 16'h0100, 16'd0);
    send_instr(OP_PUSH, KIND_IMM, KIND_REG, 16'hBEEF, 16'd0);
    send_instr(OP_POP, KIND_REG, KIND_REG, 16'd6, 16'd0);
    send_instr(OP_RET, KIND_REG, KIND_REG, 16'd0, 16'd0);
    // Errors: halt, unknown opcode, bad kinds, bad register index.
    send_instr(OP_HLT, KIND_REG, KIND_REG, 16'd0, 16'd0);
    send_instr(5'd31, KIND_REG, KIND_REG, 16'd0, 16'd0);
    send_instr(OP_ADD, KIND_IMM, KIND_REG, 16'd0, 16'd0);
    send_instr(OP_MOV, KIND_REG, 2'd3, 16'd0, 16'd0);
    send_instr(OP_INC, KIND_REG, KIND_REG, 16'hFFFF, 16'd0);
  endtask

  // Drive the stack to overflow, then pop it back down; random pop indices may be out of range.
  task automatic run_stack_limits();
    repeat (SDEPTH + 2) send_instr(OP_PUSH, KIND_IMM, pick_kind(), 16'($urandom), 16'($urandom));
    send_instr(OP_CALL, KIND_IMM, KIND_REG, 16'h0200, 16'd0);
    repeat (SDEPTH + 2) send_instr(OP_POP, KIND_REG, KIND_REG, pick_arg(0), 16'd0);
  endtask

  // Sender: directed part, the stack limits, then random instructions.
  initial begin
    sb.clear();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_stack_limits();
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - 200) quiet_tail = 1'b1;
      send_random();
    end
    push <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls, one long hold-off early on, checks at posedge.
  initial begin
    int gap;
    @(posedge rst_n);
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles < 200 && $time > 100) begin
        pop <= 1'b0;
        hold_cycles++;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 13);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && pop && !empty) begin
      got.status        = status_t'(out_status);
      got.ip_after      = out_ip_after;
      got.flags_after   = out_flags_after;
      got.reg_written   = out_reg_written;
      got.written_index = out_written_index;
      got.written_value = out_written_value;
      sb.check_result(got);
    end
  end

  // Watchdog: count cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_watch <= 0;
    else idle_watch <= idle_watch + 1;
  end

  // The run ends once everything is sent and checked, or when the block
  // stops moving items on either side for too long.
  initial begin
    idle_watch = 0;
    while (!(sending_done && sb.owed.size() == 0) && idle_watch < WATCH_MAX)
      @(posedge clk);
    if (idle_watch >= WATCH_MAX) begin
      $display("Verification failed");
    end else begin
      // Allow any result still in flight to show up as unexpected.
      repeat (10) @(posedge clk);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/tcpu_pkg.sv
rtl/tcpu_ram.sv
rtl/tcpu_front.sv
rtl/tcpu_queue.sv
rtl/tcpu_back.sv
rtl/toy_cpu_execute_unit.sv
test/tb_top.sv
